@@ rtl/core/crc16_reflected_stream_top_assert.svh @@
// Assertion macros shared by the CRC-16 stream RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef CRC16_REFLECTED_STREAM_TOP_ASSERT_SVH
`define CRC16_REFLECTED_STREAM_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CRCRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CRCRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/crcrs_pkg.sv @@
// Shared types, constants and the byte fold function for the CRC-16 stream.
// No dependencies.
package crcrs_pkg;

  localparam int CRC_W  = 16;
  localparam int BYTE_W = 8;

  // Register reset values (CRC-16/ARC)
  localparam logic [CRC_W-1:0] POLY_RESET  = 16'hA001;
  localparam logic [CRC_W-1:0] START_RESET = 16'h0000;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_POLY  = 1'b0,
    REG_START = 1'b1
  } reg_idx_t;

  // Write-back request into the CRC store
  typedef struct packed {
    logic             en;
    logic [CRC_W-1:0] crc;
  } crc_wr_t;

  // Fold one byte into a reflected CRC: eight LSB-first shift steps.
  function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data,
                                                 input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/crcrs_crc_store.sv @@
// Running-CRC store: one-entry synchronous memory with registered read and
// write-to-read forwarding. Depends on crcrs_pkg.
module crcrs_crc_store (
  input  logic                        clk,
  input  logic                        rst,
  input  crcrs_pkg::crc_wr_t          wr,
  output logic [crcrs_pkg::CRC_W-1:0] rd_crc
);

  logic [crcrs_pkg::CRC_W-1:0] crc_mem [1];
  logic [crcrs_pkg::CRC_W-1:0] rd_data;
  logic [crcrs_pkg::CRC_W-1:0] fwd_crc;
  logic                        fwd_hit;

  // Memory: write one entry, read it every cycle (read data registered)
  always_ff @(posedge clk) begin
    if (wr.en) begin
      crc_mem[0] <= wr.crc;
    end
    rd_data <= crc_mem[0];
  end

  // A write at the last edge is not yet in rd_data; bypass it
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= wr.en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      fwd_crc <= wr.crc;
    end
  end

  assign rd_crc = fwd_hit ? fwd_crc : rd_data;

endmodule

@@ rtl/core/crc16_reflected_stream_top.sv @@
// Top level of the reflected CRC-16 byte stream engine.
// Depends on crcrs_pkg, crcrs_crc_store and crc16_reflected_stream_top_assert.svh.
//
// Usage:
//   s_axis: one message byte per transaction. tdata = data_byte[7:0],
//           tlast = last_byte (final byte of a message).
//   m_axis: one result per input transaction. tdata = crc_value[15:0],
//           tlast = message_end (tdata is the final CRC of the message).
//   cfg:    cfg_wr_en/cfg_addr/cfg_wdata write poly_reflected (index 0) or
//           start_value (index 1); write only while the stream is idle.
// Path: accepted byte -> compute stage -> output register -> m_axis.
//   Throughput: one byte per cycle while m_axis is not stalled; the CRC fold
//   (eight shift steps) runs in the single compute stage and the running CRC
//   is read from and written back to a one-entry memory with a forwarding path.
// Reset: poly = 0xA001, start = 0x0000 (CRC-16/ARC); the first byte after
//   reset starts a new message. The memory itself is not cleared.
// Stall: when m_axis_tready is low the output register holds, the compute
//   stage holds one more byte, then s_axis_tready drops. No data is lost.
module crc16_reflected_stream_top (
  input  logic                         clk,
  input  logic                         rst,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [crcrs_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
  input  logic                         s_axis_tlast,   // last_byte
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [crcrs_pkg::CRC_W-1:0]  m_axis_tdata,   // [15:0] crc_value
  output logic                         m_axis_tlast,   // message_end
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [0:0]                   cfg_addr,
  input  logic [crcrs_pkg::CRC_W-1:0]  cfg_wdata
);

`include "crc16_reflected_stream_top_assert.svh"

  // Configuration registers
  logic [crcrs_pkg::CRC_W-1:0] poly;
  logic [crcrs_pkg::CRC_W-1:0] start_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly      <= crcrs_pkg::POLY_RESET;
      start_val <= crcrs_pkg::START_RESET;
    end else if (cfg_wr_en) begin
      unique case (crcrs_pkg::reg_idx_t'(cfg_addr))
        crcrs_pkg::REG_POLY:  poly      <= cfg_wdata;
        crcrs_pkg::REG_START: start_val <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Compute stage: byte waiting for the memory read of the running CRC
  logic                         s1_valid;
  logic [crcrs_pkg::BYTE_W-1:0] s1_byte;
  logic                         s1_last;
  logic                         s1_fire;
  logic                         at_start;
  logic                         in_fire;

  logic [crcrs_pkg::CRC_W-1:0]  stored_crc;
  logic [crcrs_pkg::CRC_W-1:0]  base_crc;
  logic [crcrs_pkg::CRC_W-1:0]  crc_next;
  crcrs_pkg::crc_wr_t           crc_wr;

  // Stage advances whenever the output register is free or being drained
  assign s1_fire       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte <= s_axis_tdata;
      s1_last <= s_axis_tlast;
    end
  end

  // Message boundary flag: next byte folds into start_val
  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
    end else if (s1_fire) begin
      at_start <= s1_last;
    end
  end

  crcrs_crc_store u_store (
    .clk    (clk),
    .rst    (rst),
    .wr     (crc_wr),
    .rd_crc (stored_crc)
  );

  assign base_crc   = at_start ? start_val : stored_crc;
  assign crc_next   = crcrs_pkg::fold_byte(base_crc, s1_byte, poly);
  assign crc_wr.en  = s1_fire;
  assign crc_wr.crc = crc_next;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      m_axis_tdata <= crc_next;
      m_axis_tlast <= s1_last;
    end
  end

  // Checks
  `CRCRS_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_fire, s1_valid && $stable(s1_byte), "compute stage lost a byte while stalled")
  `CRCRS_ASSERT_NEXT(a_restart, s1_fire && s1_last, at_start, "no restart after last byte")
  `CRCRS_ASSERT_NEXT(a_continue, s1_fire && !s1_last, !at_start, "restart inside a message")
  `CRCRS_ASSERT_NOW(a_backpress, !s_axis_tready, s1_valid && m_axis_tvalid && !m_axis_tready, "input stalled without full pipeline")
  `CRCRS_ASSERT_NEXT(a_out_load, s1_fire, m_axis_tvalid && m_axis_tdata == $past(crc_next), "result not loaded into output register")

endmodule

@@ verif/crc16_reflected_stream_top_tb.sv @@
// Self-checking testbench for crc16_reflected_stream_top (reflected CRC-16 byte stream).
// Depends on crcrs_pkg and the RTL only. Directed checks first, then random messages
// under several register settings, with random gaps on both streams.
module crc16_reflected_stream_top_tb;

  // One expected result: running CRC and the end-of-message flag
  typedef struct {
    logic [crcrs_pkg::CRC_W-1:0] crc;
    logic                        msg_end;
  } crc_result_t;

  logic                         clk           = 1'b0;
  logic                         rst           = 1'b1;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [crcrs_pkg::BYTE_W-1:0] s_axis_tdata  = '0;   // [7:0] data_byte
  logic                         s_axis_tlast  = 1'b0; // last_byte
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [crcrs_pkg::CRC_W-1:0]  m_axis_tdata;         // [15:0] crc_value
  logic                         m_axis_tlast;         // message_end
  logic                         cfg_wr_en     = 1'b0;
  logic [0:0]                   cfg_addr      = '0;
  logic [crcrs_pkg::CRC_W-1:0]  cfg_wdata     = '0;

  // Local copy of the block's registers and CRC state
  logic [crcrs_pkg::CRC_W-1:0]  poly_q    = crcrs_pkg::POLY_RESET;
  logic [crcrs_pkg::CRC_W-1:0]  start_q   = crcrs_pkg::START_RESET;
  logic [crcrs_pkg::CRC_W-1:0]  running_q = '0;
  bit                           opening   = 1'b1;  // next byte starts a new message

  crc_result_t                  expected_crcs[$];

  int                           bytes_sent;
  int                           messages_done;
  int                           cfg_writes;
  int                           results_checked;
  int                           mismatches;
  int                           stall_left;
  bit                           no_idle;   // suppresses gaps and stalls on both sides

  crc16_reflected_stream_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Reflected fold: XOR the byte into the low end, then eight LSB-first shifts,
  // XORing the polynomial in whenever a one drops out.
  function automatic logic [crcrs_pkg::CRC_W-1:0] crc_fold_byte(
      input logic [crcrs_pkg::CRC_W-1:0]  crc,
      input logic [crcrs_pkg::BYTE_W-1:0] b,
      input logic [crcrs_pkg::CRC_W-1:0]  poly);
    logic [crcrs_pkg::CRC_W-1:0] c;
    c = crc ^ {{(crcrs_pkg::CRC_W-crcrs_pkg::BYTE_W){1'b0}}, b};
    repeat (crcrs_pkg::BYTE_W) c = (c >> 1) ^ (c[0] ? poly : {crcrs_pkg::CRC_W{1'b0}});
    return c;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(12, 40);
  endfunction

  // Send one byte; on acceptance advance the local CRC and queue the expected result.
  // tvalid is lowered only at the step where a gap starts, so it never gets two
  // assignments in one step.
  task automatic send_byte(input logic [crcrs_pkg::BYTE_W-1:0] b, input logic l);
    int                          gap;
    logic [crcrs_pkg::CRC_W-1:0] base;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    // message start folds into the start register, otherwise into the running CRC
    base      = opening ? start_q : running_q;
    running_q = crc_fold_byte(base, b, poly_q);
    opening   = l;
    expected_crcs.push_back('{running_q, l});
    bytes_sent++;
    if (l) messages_done++;
  endtask

  // Stop sending and wait until every queued result has been checked,
  // then let the pipeline settle so it is empty before a register write.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_crcs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; a quiet wait after it keeps cfg_wr_en to one update per step
  task automatic write_reg(input crcrs_pkg::reg_idx_t idx,
                           input logic [crcrs_pkg::CRC_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      crcrs_pkg::REG_POLY:  poly_q  = v;
      crcrs_pkg::REG_START: start_q = v;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  // Result side: compare each transaction with the oldest expectation, and
  // throttle tready with random stalls.
  always @(posedge clk) begin : result_check
    crc_result_t exp_r;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_crcs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: crc=%h end=%b", $realtime, m_axis_tdata,
                     m_axis_tlast);
        end else begin
          exp_r = expected_crcs.pop_front();
          results_checked++;
          if (m_axis_tdata !== exp_r.crc || m_axis_tlast !== exp_r.msg_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: crc exp=%h got=%h, end exp=%b got=%b", $realtime,
                       exp_r.crc, m_axis_tdata, exp_r.msg_end, m_axis_tlast);
          end
        end
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  // Standard check string "123456789" with the reset registers (CRC-16/ARC)
  task automatic test_check_string();
    for (int i = 0; i < 9; i++) send_byte(8'(8'h31 + i), i == 8);
    drain();
  endtask

  // Byte extremes, single-byte messages and a two-byte message
  task automatic test_byte_extremes();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();
  endtask

  // All-ones and all-zeros registers; start value written before a message
  // opens must apply to its first byte
  task automatic test_register_extremes();
    write_reg(crcrs_pkg::REG_POLY, 16'hFFFF);
    write_reg(crcrs_pkg::REG_START, 16'hFFFF);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    drain();
    write_reg(crcrs_pkg::REG_POLY, 16'h0000);
    write_reg(crcrs_pkg::REG_START, 16'h0000);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b1);
    drain();
  endtask

  // Writes inside a message: new start value waits for the next message,
  // new polynomial applies from the next byte
  task automatic test_mid_message_writes();
    write_reg(crcrs_pkg::REG_POLY, crcrs_pkg::POLY_RESET);
    write_reg(crcrs_pkg::REG_START, crcrs_pkg::START_RESET);
    send_byte(8'h31, 1'b0);
    drain();
    write_reg(crcrs_pkg::REG_START, 16'h1234);
    write_reg(crcrs_pkg::REG_POLY, 16'h8408);
    send_byte(8'h32, 1'b0);
    send_byte(8'h33, 1'b1);
    send_byte(8'h34, 1'b1);
    drain();
  endtask

  // Random messages over ten register settings; messages run across the
  // phase boundaries, so many writes land mid-message
  task automatic test_random_stream();
    int left;
    int r;
    left = 0;
    for (int p = 0; p < 10; p++) begin
      drain();
      case (p)
        0: begin
          write_reg(crcrs_pkg::REG_POLY, crcrs_pkg::POLY_RESET);
          write_reg(crcrs_pkg::REG_START, crcrs_pkg::START_RESET);
        end
        1: begin
          write_reg(crcrs_pkg::REG_POLY, 16'hFFFF);
          write_reg(crcrs_pkg::REG_START, 16'hFFFF);
        end
        2: begin
          write_reg(crcrs_pkg::REG_POLY, 16'h0000);
          write_reg(crcrs_pkg::REG_START, 16'h0000);
        end
        3: begin
          write_reg(crcrs_pkg::REG_POLY, 16'h8408);
          write_reg(crcrs_pkg::REG_START, 16'hFFFF);
        end
        default: begin
          write_reg(crcrs_pkg::REG_POLY, 16'($urandom_range(0, 16'hFFFF)));
          write_reg(crcrs_pkg::REG_START, 16'($urandom_range(0, 16'hFFFF)));
        end
      endcase
      no_idle = (p % 4 == 3);
      for (int k = 0; k < 75; k++) begin
        if (left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 70) left = $urandom_range(1, 8);
          else if (r < 95) left = $urandom_range(9, 32);
          else left = $urandom_range(33, 80);
        end
        send_byte(8'($urandom_range(0, 255)), left == 1);
        left--;
      end
    end
    drain();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_check_string();
    test_byte_extremes();
    test_register_extremes();
    test_mid_message_writes();
    test_random_stream();
    repeat (10) @(posedge clk);
    $display("Covered %0d bytes in %0d complete messages, %0d register writes",
             bytes_sent, messages_done, cfg_writes);
    $display("Checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && expected_crcs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/crcrs_pkg.sv
rtl/core/crcrs_crc_store.sv
rtl/core/crc16_reflected_stream_top.sv
verif/crc16_reflected_stream_top_tb.sv
